// ----- sv/mmde_pkg.sv -----
// Shared constants, codes and control structs for the matrix multiply dot engine.
package mmde_pkg;

  // Fixed field widths of the ports
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned ELEM_W    = 16;
  localparam int unsigned SIZE_W    = 5;
  localparam int unsigned PROD_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_DIM_DEF   = 16;
  localparam int unsigned ELEM_BITS_DEF = 16;

  // Size register value after reset
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_WR_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WR_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RD   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  // Sequencer to multiply-accumulate unit
  typedef struct packed {
    logic clear;     // start a new sum
    logic op_valid;  // operand pair arrives from the stores
    logic op_last;   // this pair closes the dot product
  } mac_ctrl_t;

  // Multiply-accumulate unit to sequencer
  typedef struct packed {
    logic done;      // last term is being added at this edge
  } mac_stat_t;

endpackage

// ----- sv/matrix_multiply_dot_engine.sv -----
// Top level: operand stores, read sequencer and result register of the dot engine.
//
// Usage
//   Input channel (in_valid / in_stall): kind 0 writes element (row_index, col_index)
//   of A, kind 1 of B; kind 2 asks for product element (row_index, col_index); kind 3
//   is dropped. Writes outside the configured sizes are dropped and give no result.
//   Output channel (out_valid / out_stall): one transfer per kind 2 item, carrying
//   the saturated Q16.16 product_value and index_error (set, with a zero value, when
//   the index lies outside the sizes or inner_dim is zero).
//   Configuration (cfg_valid / cfg_ready, always ready): index 0 rows_a,
//   1 inner_dim, 2 cols_b; sizes above MAX_DIM act as MAX_DIM. Write only when idle.
// Timing
//   A write is stored when it transfers. A product read walks the row of A and the
//   column of B one inner element per cycle through the store read ports and the
//   single multiply-accumulate, passing the store read register, the product
//   register and the accumulator, then a combinational saturation into the output
//   register. The next item may transfer once the result is loaded; a read holds
//   the input until then. An index error skips the walk, going straight to the
//   output register. One item is in work at a time.
// Reset and stall
//   Reset sets all sizes to 16 and empties the output; store contents are undefined
//   until written. A finished result waits in the output register while out_stall is
//   high; a new input item may transfer meanwhile and its result waits in turn.
module matrix_multiply_dot_engine #(
  parameter int unsigned MAX_DIM   = mmde_pkg::MAX_DIM_DEF,
  parameter int unsigned ELEM_BITS = mmde_pkg::ELEM_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input items
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mmde_pkg::KIND_W-1:0]       kind,
  input  logic [mmde_pkg::IDX_W-1:0]        row_index,
  input  logic [mmde_pkg::IDX_W-1:0]        col_index,
  input  logic signed [mmde_pkg::ELEM_W-1:0] element,
  // results
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [mmde_pkg::PROD_W-1:0] product_value,
  output logic                              index_error,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mmde_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mmde_pkg::SIZE_W-1:0]       cfg_data
);

  localparam int unsigned EW      = (ELEM_BITS < mmde_pkg::ELEM_W) ? ELEM_BITS
                                                                   : mmde_pkg::ELEM_W;
  localparam int unsigned DEPTH   = MAX_DIM * MAX_DIM;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned ACC_W   = 2 * EW + 5;
  localparam int unsigned DIM_CAP = (MAX_DIM > 31) ? 31 : MAX_DIM;
  localparam logic [mmde_pkg::SIZE_W-1:0] DIM_CAP_S = mmde_pkg::SIZE_W'(DIM_CAP);
  localparam logic [AW-1:0] ROW_STEP = AW'(MAX_DIM);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RUN    = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [mmde_pkg::SIZE_W-1:0] rows_a;
  logic [mmde_pkg::SIZE_W-1:0] inner_dim;
  logic [mmde_pkg::SIZE_W-1:0] cols_b;
  logic [mmde_pkg::SIZE_W-1:0] na;
  logic [mmde_pkg::SIZE_W-1:0] nk;
  logic [mmde_pkg::SIZE_W-1:0] nb;
  logic [mmde_pkg::SIZE_W-1:0] row_ext;
  logic [mmde_pkg::SIZE_W-1:0] col_ext;

  logic          accept;
  logic          is_rd;
  logic          rd_err;
  logic          a_wen;
  logic          b_wen;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] a_addr;
  logic [AW-1:0] b_addr;
  logic [mmde_pkg::SIZE_W-1:0] k_cnt;
  logic          k_last;
  logic          rd_en;
  logic          rd_valid;
  logic          rd_last;
  logic          err;
  logic          out_load;
  logic [EW-1:0] a_rdata;
  logic [EW-1:0] b_rdata;
  logic [mmde_pkg::PROD_W-1:0] mac_sat;
  mmde_pkg::mac_ctrl_t mac_ctrl;
  mmde_pkg::mac_stat_t mac_stat;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= mmde_pkg::SIZE_RESET;
      inner_dim <= mmde_pkg::SIZE_RESET;
      cols_b    <= mmde_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mmde_pkg::REG_ROWS_A:    rows_a    <= cfg_data;
        mmde_pkg::REG_INNER_DIM: inner_dim <= cfg_data;
        mmde_pkg::REG_COLS_B:    cols_b    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp sizes to the store dimension
  assign na = (rows_a    > DIM_CAP_S) ? DIM_CAP_S : rows_a;
  assign nk = (inner_dim > DIM_CAP_S) ? DIM_CAP_S : inner_dim;
  assign nb = (cols_b    > DIM_CAP_S) ? DIM_CAP_S : cols_b;

  assign row_ext = mmde_pkg::SIZE_W'(row_index);
  assign col_ext = mmde_pkg::SIZE_W'(col_index);

  // Input handshake and decode
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_rd    = (kind == mmde_pkg::KIND_RD);
  assign rd_err   = !(row_ext < na && col_ext < nb) || (nk == '0);

  assign a_wen   = accept && (kind == mmde_pkg::KIND_WR_A) && (row_ext < na) && (col_ext < nk);
  assign b_wen   = accept && (kind == mmde_pkg::KIND_WR_B) && (row_ext < nk) && (col_ext < nb);
  assign wr_addr = AW'(int'(row_index) * MAX_DIM + int'(col_index));

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && is_rd) begin
          state_next = rd_err ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        if (k_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_stat.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk row of A and column of B, one inner element per cycle
  assign rd_en  = (state == ST_RUN);
  assign k_last = (k_cnt == nk - mmde_pkg::SIZE_W'(1));

  always_ff @(posedge clk) begin
    if (accept) begin
      a_addr <= AW'(int'(row_index) * MAX_DIM);
      b_addr <= AW'(col_index);
      k_cnt  <= '0;
      err    <= rd_err;
    end else if (rd_en) begin
      a_addr <= a_addr + AW'(1);
      b_addr <= b_addr + ROW_STEP;
      k_cnt  <= k_cnt + mmde_pkg::SIZE_W'(1);
    end
  end

  // Track read data arriving from the stores
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      rd_last  <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      rd_last  <= rd_en && k_last;
    end
  end

  mmde_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_a_store (
    .clk   (clk),
    .wen   (a_wen),
    .waddr (wr_addr),
    .wdata (element[EW-1:0]),
    .ren   (rd_en),
    .raddr (a_addr),
    .rdata (a_rdata)
  );

  mmde_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_b_store (
    .clk   (clk),
    .wen   (b_wen),
    .waddr (wr_addr),
    .wdata (element[EW-1:0]),
    .ren   (rd_en),
    .raddr (b_addr),
    .rdata (b_rdata)
  );

  assign mac_ctrl.clear    = accept;
  assign mac_ctrl.op_valid = rd_valid;
  assign mac_ctrl.op_last  = rd_last;

  mmde_mac #(
    .EW    (EW),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (mac_ctrl),
    .a_data    (a_rdata),
    .b_data    (b_rdata),
    .stat      (mac_stat),
    .sat_value (mac_sat)
  );

  // Output register: load a finished result when empty or being drained this cycle
  assign out_load = (state == ST_FINISH) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      product_value <= err ? '0 : $signed(mac_sat);
      index_error   <= err;
    end
  end

  // Checks
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_error |-> product_value == '0)
    else $error("index error result carries a nonzero value");

  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    mac_stat.done |-> state == ST_DRAIN)
    else $error("dot product finished outside the drain state");

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    (a_wen || b_wen) |-> !rd_valid && !mac_stat.done)
    else $error("store write overlaps a dot product walk");

  a_err_skips_walk: assert property (@(posedge clk) disable iff (rst)
    accept && is_rd && rd_err |=> state == ST_FINISH)
    else $error("out of range read did not go straight to the result");

endmodule

// ----- sv/mmde_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module mmde_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     ren,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/mmde_mac.sv -----
// Registered multiply, wide accumulator and 32-bit saturation for one dot product.
module mmde_mac #(
  parameter int unsigned EW    = 16,
  parameter int unsigned ACC_W = 2 * EW + 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mmde_pkg::mac_ctrl_t           ctrl,
  input  logic [EW-1:0]                 a_data,
  input  logic [EW-1:0]                 b_data,
  output mmde_pkg::mac_stat_t           stat,
  output logic [mmde_pkg::PROD_W-1:0]   sat_value
);

  localparam int unsigned SAT_W = (ACC_W > 33) ? ACC_W : 33;
  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(-64'sh0000_0000_8000_0000);

  logic signed [2*EW-1:0]  prod;
  logic                    prod_valid;
  logic                    prod_last;
  logic signed [ACC_W-1:0] acc;
  logic signed [SAT_W-1:0] acc_ext;

  // Multiply stage
  always_ff @(posedge clk) begin
    prod <= $signed(a_data) * $signed(b_data);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      prod_last  <= 1'b0;
    end else begin
      prod_valid <= ctrl.op_valid;
      prod_last  <= ctrl.op_valid && ctrl.op_last;
    end
  end

  // Accumulate stage
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign stat.done = prod_valid && prod_last;

  // Clip the exact sum to the signed 32-bit range
  assign acc_ext = SAT_W'(acc);

  always_comb begin
    if (acc_ext > SAT_MAX) begin
      sat_value = SAT_MAX[mmde_pkg::PROD_W-1:0];
    end else if (acc_ext < SAT_MIN) begin
      sat_value = SAT_MIN[mmde_pkg::PROD_W-1:0];
    end else begin
      sat_value = acc_ext[mmde_pkg::PROD_W-1:0];
    end
  end

endmodule

// ----- bench/dot_engine_checker.sv -----
// Checker for the dot engine: mirrors the operand stores, predicts each product, compares.
`timescale 1ns / 100ps
module dot_engine_checker
  import mmde_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [KIND_W-1:0]        kind,
  input  logic [IDX_W-1:0]         row_index,
  input  logic [IDX_W-1:0]         col_index,
  input  logic signed [ELEM_W-1:0] element,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [PROD_W-1:0] product_value,
  input  logic                     index_error,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [SIZE_W-1:0]        cfg_data,
  output int                       fail_count,
  output int                       pending,
  output int                       products_seen,
  output int                       errors_seen,
  output int                       saturated_seen
);
  localparam int unsigned DIM = MAX_DIM_DEF;
  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;

  typedef struct {
    logic signed [PROD_W-1:0] value;
    logic                     err;
    logic                     sat;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
  } product_t;

  logic signed [ELEM_W-1:0] a_copy [DIM*DIM];
  logic signed [ELEM_W-1:0] b_copy [DIM*DIM];
  logic [SIZE_W-1:0] rows_cfg, inner_cfg, cols_cfg;
  product_t pending_products [$];
  int fails, n_prod, n_err, n_sat;

  initial begin
    fails = 0;
    n_prod = 0;
    n_err = 0;
    n_sat = 0;
  end

  // Sizes above the store dimension act as the full dimension
  function automatic int unsigned clamp_dim(logic [SIZE_W-1:0] v);
    return (v > DIM) ? DIM : v;
  endfunction

  // Dot product of row of A with column of B, saturated to 32 bits
  function automatic product_t dot_product_of(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    product_t p;
    longint acc;
    int unsigned nk;
    int unsigned k;
    nk = clamp_dim(inner_cfg);
    p.row = r;
    p.col = c;
    p.value = '0;
    p.err = 1'b0;
    p.sat = 1'b0;
    acc = 0;
    if (r >= clamp_dim(rows_cfg) || c >= clamp_dim(cols_cfg) || nk == 0) begin
      p.err = 1'b1;
      return p;
    end
    for (k = 0; k < nk; k++)
      acc += longint'(a_copy[r*DIM + k]) * longint'(b_copy[k*DIM + c]);
    if (acc > SUM_MAX) begin
      p.value = 32'sh7FFF_FFFF;
      p.sat = 1'b1;
    end else if (acc < SUM_MIN) begin
      p.value = 32'sh8000_0000;
      p.sat = 1'b1;
    end else begin
      p.value = PROD_W'(acc);
    end
    return p;
  endfunction

  always @(posedge clk) begin : watch
    product_t want;
    if (rst) begin
      rows_cfg = SIZE_RESET;
      inner_cfg = SIZE_RESET;
      cols_cfg = SIZE_RESET;
      pending_products.delete();
    end else begin
      // Compare a result transfer with the oldest expected product
      if (out_valid && !out_stall) begin
        n_prod++;
        if (pending_products.size() == 0) begin
          fails++;
          $display("%0t: result with none expected: value %0d error %0b",
                   $time, product_value, index_error);
        end else begin
          want = pending_products.pop_front();
          if (want.err) n_err++;
          if (want.sat) n_sat++;
          if (product_value !== want.value) begin
            fails++;
            $display("%0t: product (%0d,%0d) value expected %0d actual %0d",
                     $time, want.row, want.col, want.value, product_value);
          end
          if (index_error !== want.err) begin
            fails++;
            $display("%0t: product (%0d,%0d) index_error expected %0b actual %0b",
                     $time, want.row, want.col, want.err, index_error);
          end
        end
      end

      // Track size register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROWS_A:    rows_cfg = cfg_data;
          REG_INNER_DIM: inner_cfg = cfg_data;
          REG_COLS_B:    cols_cfg = cfg_data;
          default: ;
        endcase
      end

      // Apply writes to the store copies, queue products for reads
      if (in_valid && !in_stall) begin
        case (kind)
          KIND_WR_A: begin
            if (row_index < clamp_dim(rows_cfg) && col_index < clamp_dim(inner_cfg))
              a_copy[row_index*DIM + col_index] = element;
          end
          KIND_WR_B: begin
            if (row_index < clamp_dim(inner_cfg) && col_index < clamp_dim(cols_cfg))
              b_copy[row_index*DIM + col_index] = element;
          end
          KIND_RD: pending_products.push_back(dot_product_of(row_index, col_index));
          default: ;
        endcase
      end
    end
    pending <= pending_products.size();
    fail_count <= fails;
    products_seen <= n_prod;
    errors_seen <= n_err;
    saturated_seen <= n_sat;
  end
endmodule

// ----- bench/tb_matrix_multiply_dot_engine.sv -----
// Testbench top: drives items, size writes and output stalls into the dot engine.
`timescale 1ns / 100ps
module tb_matrix_multiply_dot_engine;
  import mmde_pkg::*;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam int unsigned DIM = MAX_DIM_DEF;
  localparam int unsigned LONG_HOLD = 400;
  // longest product latency plus margin
  localparam int unsigned SETTLE = 24;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0] row_index;
  logic [IDX_W-1:0] col_index;
  logic signed [ELEM_W-1:0] element;
  logic out_valid;
  logic out_stall;
  logic signed [PROD_W-1:0] product_value;
  logic index_error;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0] cfg_data;

  int fail_count, pending, products_seen, errors_seen, saturated_seen;
  int items_sent = 0;
  int settings_used = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_request = 1'b0;
  int unsigned na = DIM;
  int unsigned nk = DIM;
  int unsigned nb = DIM;
  bit a_written [DIM*DIM];
  bit b_written [DIM*DIM];

  always #2 clk = ~clk;

  matrix_multiply_dot_engine uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .row_index(row_index), .col_index(col_index), .element(element),
    .out_valid(out_valid), .out_stall(out_stall),
    .product_value(product_value), .index_error(index_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dot_engine_checker product_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .row_index(row_index), .col_index(col_index), .element(element),
    .out_valid(out_valid), .out_stall(out_stall),
    .product_value(product_value), .index_error(index_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .products_seen(products_seen),
    .errors_seen(errors_seen), .saturated_seen(saturated_seen)
  );

  // Receiver: random stalls, or a long hold-off when requested
  initial begin : receiver
    int unsigned hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_request) begin
        hold_seen = hold_request;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic int unsigned clamp_dim(logic [SIZE_W-1:0] v);
    return (v > DIM) ? DIM : v;
  endfunction

  // Favor the extremes of Q8.8 now and then
  function automatic logic [ELEM_W-1:0] pick_element();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // Index inside the given size, any index when the size is zero
  function automatic logic [IDX_W-1:0] pick_index(int unsigned size);
    return (size == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(size - 1));
  endfunction

  // Offer one item, hold it until its transfer, note which entries now hold data
  task automatic send_item(logic [KIND_W-1:0] k, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                           logic [ELEM_W-1:0] e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    row_index <= r;
    col_index <= c;
    element <= e;
    do @(posedge clk); while (in_stall);
    if (k == KIND_WR_A && r < na && c < nk) a_written[r*DIM + c] = 1'b1;
    if (k == KIND_WR_B && r < nk && c < nb) b_written[r*DIM + c] = 1'b1;
    if (k != KIND_NONE) items_sent++;
  endtask

  // Fill any missing operands of an in-range product, then ask for it
  task automatic ask_product(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    int unsigned k;
    if (r < na && c < nb) begin
      for (k = 0; k < nk; k++) begin
        if (!a_written[r*DIM + k]) send_item(KIND_WR_A, r, IDX_W'(k), pick_element());
        if (!b_written[k*DIM + c]) send_item(KIND_WR_B, IDX_W'(k), c, pick_element());
      end
    end
    send_item(KIND_RD, r, c, ELEM_W'($urandom));
  endtask

  // Drop valid and wait until every product has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Change sizes only once the engine is idle
  task automatic set_sizes(logic [SIZE_W-1:0] ra, logic [SIZE_W-1:0] ik,
                           logic [SIZE_W-1:0] cb);
    drain();
    repeat (SETTLE) @(posedge clk);
    write_reg(REG_ROWS_A, ra);
    write_reg(REG_INNER_DIM, ik);
    write_reg(REG_COLS_B, cb);
    cfg_valid <= 1'b0;
    na = clamp_dim(ra);
    nk = clamp_dim(ik);
    nb = clamp_dim(cb);
    settings_used++;
  endtask

  // Mostly well-formed product requests, with stray writes, wild indexes and dropped kinds
  task automatic random_phase(int n);
    int stop_at;
    int unsigned sel;
    logic [KIND_W-1:0] k;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        ask_product(pick_index(na), pick_index(nb));
      end else if (sel < 65) begin
        ask_product(IDX_W'($urandom), IDX_W'($urandom));
      end else if (sel < 93) begin
        k = $urandom_range(1) ? KIND_WR_B : KIND_WR_A;
        if ($urandom_range(4) == 0)
          send_item(k, IDX_W'($urandom), IDX_W'($urandom), pick_element());
        else if (k == KIND_WR_A)
          send_item(k, pick_index(na), pick_index(nk), pick_element());
        else
          send_item(k, pick_index(nk), pick_index(nb), pick_element());
      end else begin
        send_item(KIND_NONE, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    int i;
    rst <= 1'b1;
    in_valid <= 1'b0;
    kind <= KIND_WR_A;
    row_index <= '0;
    col_index <= '0;
    element <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ROWS_A;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Sender idles lightly, receiver heavily
    send_idle_pct = 16;
    recv_idle_pct = 60;

    // Directed: saturation both ways, zero sum, range edges, dropped items
    set_sizes(15, 3, 14);
    for (i = 0; i < 3; i++) send_item(KIND_WR_A, 0, IDX_W'(i), 16'h8000);
    for (i = 0; i < 3; i++) send_item(KIND_WR_B, IDX_W'(i), 0, 16'h8000);
    ask_product(0, 0);
    for (i = 0; i < 3; i++) send_item(KIND_WR_B, IDX_W'(i), 1, 16'h7FFF);
    ask_product(0, 1);
    send_item(KIND_WR_A, 14, 0, 16'h0001);
    send_item(KIND_WR_A, 14, 1, 16'hFFFF);
    send_item(KIND_WR_A, 14, 2, 16'h0000);
    ask_product(14, 1);
    ask_product(14, 13);
    ask_product(15, 0);
    ask_product(0, 14);
    send_item(KIND_WR_A, 0, 3, 16'h1234);
    send_item(KIND_WR_B, 3, 0, 16'h1234);
    send_item(KIND_WR_A, 15, 0, 16'h1234);
    send_item(KIND_NONE, 5, 5, 16'h5A5A);
    ask_product(0, 0);

    set_sizes(16, 16, 16);
    random_phase(60);
    hold_request <= ~hold_request;
    random_phase(60);
    set_sizes(1, 1, 1);
    random_phase(50);
    set_sizes(31, 31, 31);
    random_phase(70);

    // Swap the idle rates, visit zero sizes
    send_idle_pct = 60;
    recv_idle_pct = 16;
    set_sizes(0, 4, 4);
    random_phase(25);
    set_sizes(4, 0, 4);
    random_phase(25);
    set_sizes(4, 4, 0);
    random_phase(25);
    set_sizes(5, 2, 7);
    random_phase(35);
    drain();
    random_phase(35);

    // Full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_sizes(2, 16, 3);
    random_phase(70);
    set_sizes(16, 1, 16);
    random_phase(60);
    set_sizes(16, 16, 16);
    random_phase(60);

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d items over %0d size settings, including zero and clamped sizes.",
             items_sent, settings_used);
    $display("Checked %0d products: %0d index errors, %0d saturated sums.",
             products_seen, errors_seen, saturated_seen);
    if (fail_count == 0 && pending == 0)
      $display("matrix_multiply_dot_engine regression: pass");
    else
      $display("matrix_multiply_dot_engine regression: fail");
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #2_000_000;
    $display("%0t: run timed out", $time);
    $display("matrix_multiply_dot_engine regression: fail");
    $finish;
  end
endmodule
